// ===== hdl/imta_pkg.sv =====
// Shared types, constants and helpers for the mosaic tile average block.
package imta_pkg;

	localparam int DEF_MAX_IMAGE_WIDTH  = 4096;
	localparam int DEF_MAX_IMAGE_HEIGHT = 4096;
	localparam int DEF_MAX_CELL_SIZE    = 64;

	localparam int RST_CELL_SIZE    = 8;
	localparam int RST_IMAGE_WIDTH  = 640;
	localparam int RST_IMAGE_HEIGHT = 480;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam int PIX_W   = 8;
	localparam int SUM_W   = 20;
	localparam int TOT_W   = 32;
	localparam int POS_W   = 12;
	localparam int NCOLOR  = 3;
	localparam int Q_DEPTH = 2;

	// One completed tile on its way from the accumulator to the divider.
	typedef struct packed {
		logic [POS_W-1:0]  tile_row;
		logic [POS_W-1:0]  tile_col;
		logic [SUM_W-1:0]  sum_r;
		logic [SUM_W-1:0]  sum_g;
		logic [SUM_W-1:0]  sum_b;
		logic [TOT_W-1:0]  cnt;
		logic [TOT_W-1:0]  px;
		logic [TOT_W-1:0]  tot_r;
		logic [TOT_W-1:0]  tot_g;
		logic [TOT_W-1:0]  tot_b;
		logic              done;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Zero maps to one, anything above the limit saturates to it.
	function automatic logic [31:0] clamp_range(input logic [31:0] v, input logic [31:0] hi);
		logic [31:0] r;
		r = v;
		if (v == 32'd0) begin
			r = 32'd1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ===== hdl/imta_front.sv =====
// Pixel front end: position tracking, band sums, totals and tile completion.
module imta_front #(
	parameter int MAX_IMAGE_WIDTH  = imta_pkg::DEF_MAX_IMAGE_WIDTH,
	parameter int MAX_IMAGE_HEIGHT = imta_pkg::DEF_MAX_IMAGE_HEIGHT,
	parameter int MAX_CELL_SIZE    = imta_pkg::DEF_MAX_CELL_SIZE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [imta_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imta_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [imta_pkg::PIX_W-1:0]           red,
	input  logic [imta_pkg::PIX_W-1:0]           green,
	input  logic [imta_pkg::PIX_W-1:0]           blue,
	output logic                                 push,
	output imta_pkg::entry_t                     entry,
	input  imta_pkg::fifo_stat_t                 fifo_stat
);
	import imta_pkg::*;

	localparam int W_B    = $clog2(MAX_IMAGE_WIDTH + 1);
	localparam int H_B    = $clog2(MAX_IMAGE_HEIGHT + 1);
	localparam int CS_B   = $clog2(MAX_CELL_SIZE + 1);
	localparam int TC_IDX = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
	localparam int MEM_W  = NCOLOR * SUM_W;

	logic [CS_B-1:0]  cs_q;
	logic [W_B-1:0]   w_q, col_q, tc_q, x0_q;
	logic [H_B-1:0]   h_q, row_q, tr_q, y0_q;
	logic [CS_B-1:0]  cin_q, rin_q;
	logic [TOT_W-1:0] tot_q [NCOLOR];

	logic             accept, cfg_we;
	logic             first, last_col, last_row, done, cend, rend, complete;
	logic [CS_B-1:0]  tw, th;
	logic [PIX_W-1:0] pix [NCOLOR];
	logic [TOT_W-1:0] tot_nx [NCOLOR];

	logic             v_s1, first_s1, fwd_s1, complete_s1, done_s1, adv_s1;
	logic [W_B-1:0]   tc_s1;
	logic [H_B-1:0]   tr_s1;
	logic [CS_B-1:0]  tw_s1, th_s1;
	logic [PIX_W-1:0] pix_s1 [NCOLOR];
	logic [TOT_W-1:0] tot_s1 [NCOLOR];

	logic [MEM_W-1:0] mem [MAX_IMAGE_WIDTH];
	logic [MEM_W-1:0] rd_q;
	logic [SUM_W-1:0] last_q [NCOLOR];
	logic [SUM_W-1:0] base [NCOLOR];
	logic [SUM_W-1:0] nsum [NCOLOR];
	logic [2*CS_B-1:0] cnt_p;
	logic [W_B+H_B-1:0] px_p;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;
	assign accept    = in_valid && in_ready;

	assign pix[0] = red;
	assign pix[1] = green;
	assign pix[2] = blue;

	always_comb begin
		first    = (cin_q == '0) && (rin_q == '0);
		last_col = (32'(col_q) + 32'd1) == 32'(w_q);
		last_row = (32'(row_q) + 32'd1) == 32'(h_q);
		done     = last_col && last_row;
		cend     = (32'(cin_q) + 32'd1) == 32'(cs_q);
		rend     = (32'(rin_q) + 32'd1) == 32'(cs_q);
		complete = (cend || last_col) && (rend || last_row);
		tw = CS_B'(((32'(w_q) - 32'(x0_q)) > 32'(cs_q)) ? 32'(cs_q) : (32'(w_q) - 32'(x0_q)));
		th = CS_B'(((32'(h_q) - 32'(y0_q)) > 32'(cs_q)) ? 32'(cs_q) : (32'(h_q) - 32'(y0_q)));
		for (int i = 0; i < NCOLOR; i++) begin
			tot_nx[i] = tot_q[i] + 32'(pix[i]);
		end
	end

	// A completed tile can only leave when the queue has room.
	assign adv_s1   = v_s1 && (!complete_s1 || !fifo_stat.full);
	assign in_ready = !v_s1 || adv_s1;
	assign push     = v_s1 && complete_s1 && !fifo_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q  <= CS_B'(clamp_range(32'(RST_CELL_SIZE), 32'(MAX_CELL_SIZE)));
			w_q   <= W_B'(clamp_range(32'(RST_IMAGE_WIDTH), 32'(MAX_IMAGE_WIDTH)));
			h_q   <= H_B'(clamp_range(32'(RST_IMAGE_HEIGHT), 32'(MAX_IMAGE_HEIGHT)));
			col_q <= '0;
			row_q <= '0;
			cin_q <= '0;
			rin_q <= '0;
			tc_q  <= '0;
			tr_q  <= '0;
			x0_q  <= '0;
			y0_q  <= '0;
			for (int i = 0; i < NCOLOR; i++) tot_q[i] <= '0;
		end else if (cfg_we && (cfg_index == CFG_CELL_SIZE || cfg_index == CFG_IMAGE_WIDTH ||
		                        cfg_index == CFG_IMAGE_HEIGHT)) begin
			unique case (cfg_index)
				CFG_CELL_SIZE: begin
					cs_q <= CS_B'(clamp_range(32'(cfg_data[6:0]), 32'(MAX_CELL_SIZE)));
				end
				CFG_IMAGE_WIDTH: begin
					w_q <= W_B'(clamp_range(32'(cfg_data), 32'(MAX_IMAGE_WIDTH)));
				end
				default: begin
					h_q <= H_B'(clamp_range(32'(cfg_data), 32'(MAX_IMAGE_HEIGHT)));
				end
			endcase
			// Any register write restarts the image.
			col_q <= '0;
			row_q <= '0;
			cin_q <= '0;
			rin_q <= '0;
			tc_q  <= '0;
			tr_q  <= '0;
			x0_q  <= '0;
			y0_q  <= '0;
			for (int i = 0; i < NCOLOR; i++) tot_q[i] <= '0;
		end else if (accept) begin
			if (done) begin
				col_q <= '0;
				row_q <= '0;
				cin_q <= '0;
				rin_q <= '0;
				tc_q  <= '0;
				tr_q  <= '0;
				x0_q  <= '0;
				y0_q  <= '0;
				for (int i = 0; i < NCOLOR; i++) tot_q[i] <= '0;
			end else begin
				for (int i = 0; i < NCOLOR; i++) tot_q[i] <= tot_nx[i];
				if (last_col) begin
					col_q <= '0;
					cin_q <= '0;
					tc_q  <= '0;
					x0_q  <= '0;
					row_q <= row_q + 1'b1;
					if (rend) begin
						rin_q <= '0;
						tr_q  <= tr_q + 1'b1;
						y0_q  <= H_B'(32'(y0_q) + 32'(cs_q));
					end else begin
						rin_q <= rin_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
					if (cend) begin
						cin_q <= '0;
						tc_q  <= tc_q + 1'b1;
						x0_q  <= W_B'(32'(x0_q) + 32'(cs_q));
					end else begin
						cin_q <= cin_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tc_s1       <= tc_q;
			tr_s1       <= tr_q;
			tw_s1       <= tw;
			th_s1       <= th;
			first_s1    <= first;
			complete_s1 <= complete;
			done_s1     <= done;
			// The entry read at this edge misses a write landing at the same edge.
			fwd_s1      <= adv_s1 && (tc_s1 == tc_q);
			for (int i = 0; i < NCOLOR; i++) begin
				pix_s1[i] <= pix[i];
				tot_s1[i] <= tot_nx[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NCOLOR; i++) begin
			if (first_s1) begin
				base[i] = '0;
			end else if (fwd_s1) begin
				base[i] = last_q[i];
			end else begin
				base[i] = rd_q[(NCOLOR-1-i)*SUM_W +: SUM_W];
			end
			nsum[i] = base[i] + SUM_W'(pix_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mem[tc_s1[TC_IDX-1:0]] <= {nsum[0], nsum[1], nsum[2]};
			for (int i = 0; i < NCOLOR; i++) last_q[i] <= nsum[i];
		end
		if (accept) begin
			rd_q <= mem[tc_q[TC_IDX-1:0]];
		end
	end

	assign cnt_p = tw_s1 * th_s1;
	assign px_p  = w_q * h_q;

	always_comb begin
		entry.tile_row = POS_W'(32'(tr_s1));
		entry.tile_col = POS_W'(32'(tc_s1));
		entry.sum_r    = nsum[0];
		entry.sum_g    = nsum[1];
		entry.sum_b    = nsum[2];
		entry.cnt      = TOT_W'(cnt_p);
		entry.px       = TOT_W'(px_p);
		entry.tot_r    = tot_s1[0];
		entry.tot_g    = tot_s1[1];
		entry.tot_b    = tot_s1[2];
		entry.done     = done_s1;
	end

endmodule

// ===== hdl/imta_fifo.sv =====
// Short queue of completed tiles between the accumulator and the divider.
module imta_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  imta_pkg::entry_t     wdata,
	input  logic                 pop,
	output imta_pkg::entry_t     rdata,
	output imta_pkg::fifo_stat_t stat
);
	import imta_pkg::*;

	localparam int PTR_B = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_B = $clog2(Q_DEPTH + 1);

	entry_t           slot_q [Q_DEPTH];
	logic [PTR_B-1:0] wr_q, rd_q;
	logic [CNT_B-1:0] cnt_q;

	assign rdata      = slot_q[rd_q];
	assign stat.full  = (32'(cnt_q) == 32'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == 32'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == 32'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/imta_back.sv =====
// Back end: six-lane restoring divider for tile and image averages, output register.
module imta_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  imta_pkg::entry_t             entry,
	input  imta_pkg::fifo_stat_t         fifo_stat,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [imta_pkg::POS_W-1:0]   tile_row,
	output logic [imta_pkg::POS_W-1:0]   tile_col,
	output logic [imta_pkg::PIX_W-1:0]   tile_red,
	output logic [imta_pkg::PIX_W-1:0]   tile_green,
	output logic [imta_pkg::PIX_W-1:0]   tile_blue,
	output logic                         image_done,
	output logic [imta_pkg::PIX_W-1:0]   image_red,
	output logic [imta_pkg::PIX_W-1:0]   image_green,
	output logic [imta_pkg::PIX_W-1:0]   image_blue
);
	import imta_pkg::*;

	localparam int NLANE  = 2 * NCOLOR;
	localparam int STEP_B = $clog2(TOT_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_B-1:0] step_q;
	logic [TOT_W-1:0]  dvd_q [NLANE];
	logic [TOT_W:0]    rem_q [NLANE];
	logic [TOT_W-1:0]  dvs_q [NLANE];
	logic [POS_W-1:0]  tr_q, tc_q;
	logic              done_q;

	logic [TOT_W:0]    rem_sh [NLANE];
	logic [TOT_W:0]    rem_nx [NLANE];
	logic [TOT_W-1:0]  dvd_nx [NLANE];
	logic              ge [NLANE];
	logic              out_free;

	assign pop      = (state_q == ST_IDLE) && !fifo_stat.empty;
	assign out_free = !out_valid || out_ready;

	// One quotient bit per lane and cycle; the quotient shifts in behind the dividend.
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			rem_sh[i] = {rem_q[i][TOT_W-1:0], dvd_q[i][TOT_W-1]};
			ge[i]     = rem_sh[i] >= {1'b0, dvs_q[i]};
			rem_nx[i] = ge[i] ? (rem_sh[i] - {1'b0, dvs_q[i]}) : rem_sh[i];
			dvd_nx[i] = {dvd_q[i][TOT_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (32'(step_q) == 32'(TOT_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q[0] <= TOT_W'(entry.sum_r);
			dvd_q[1] <= TOT_W'(entry.sum_g);
			dvd_q[2] <= TOT_W'(entry.sum_b);
			dvd_q[3] <= entry.tot_r;
			dvd_q[4] <= entry.tot_g;
			dvd_q[5] <= entry.tot_b;
			for (int i = 0; i < NCOLOR; i++) begin
				dvs_q[i]          <= entry.cnt;
				dvs_q[i + NCOLOR] <= entry.px;
			end
			for (int i = 0; i < NLANE; i++) rem_q[i] <= '0;
			tr_q   <= entry.tile_row;
			tc_q   <= entry.tile_col;
			done_q <= entry.done;
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < NLANE; i++) begin
				dvd_q[i] <= dvd_nx[i];
				rem_q[i] <= rem_nx[i];
			end
		end
		if (state_q == ST_FIN && out_free) begin
			tile_row    <= tr_q;
			tile_col    <= tc_q;
			tile_red    <= dvd_q[0][PIX_W-1:0];
			tile_green  <= dvd_q[1][PIX_W-1:0];
			tile_blue   <= dvd_q[2][PIX_W-1:0];
			image_done  <= done_q;
			image_red   <= done_q ? dvd_q[3][PIX_W-1:0] : '0;
			image_green <= done_q ? dvd_q[4][PIX_W-1:0] : '0;
			image_blue  <= done_q ? dvd_q[5][PIX_W-1:0] : '0;
		end
	end

endmodule

// ===== hdl/image_mosaic_tile_average_top.sv =====
// A tile's last pixel is registered in stage 1, queued, run through the divider and
// the output register. Throughput: one pixel per cycle while the two-entry tile queue
// has room; each tile occupies the divider for a 32-step restoring division plus load
// and hand-off, so tile rate, not pixel rate, sets the pace for very small cells.
// Reset: clears positions, totals, queue and handshake state; band sums are not cleared.
module image_mosaic_tile_average_top #(
	parameter int MAX_IMAGE_WIDTH  = imta_pkg::DEF_MAX_IMAGE_WIDTH,
	parameter int MAX_IMAGE_HEIGHT = imta_pkg::DEF_MAX_IMAGE_HEIGHT,
	parameter int MAX_CELL_SIZE    = imta_pkg::DEF_MAX_CELL_SIZE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [imta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imta_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [imta_pkg::PIX_W-1:0]       red,
	input  logic [imta_pkg::PIX_W-1:0]       green,
	input  logic [imta_pkg::PIX_W-1:0]       blue,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [imta_pkg::POS_W-1:0]       tile_row,
	output logic [imta_pkg::POS_W-1:0]       tile_col,
	output logic [imta_pkg::PIX_W-1:0]       tile_red,
	output logic [imta_pkg::PIX_W-1:0]       tile_green,
	output logic [imta_pkg::PIX_W-1:0]       tile_blue,
	output logic                             image_done,
	output logic [imta_pkg::PIX_W-1:0]       image_red,
	output logic [imta_pkg::PIX_W-1:0]       image_green,
	output logic [imta_pkg::PIX_W-1:0]       image_blue
);
	import imta_pkg::*;

	logic       push, pop;
	entry_t     wr_entry, rd_entry;
	fifo_stat_t fifo_stat;

	imta_front #(
		.MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
		.MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT),
		.MAX_CELL_SIZE   (MAX_CELL_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.push      (push),
		.entry     (wr_entry),
		.fifo_stat (fifo_stat)
	);

	imta_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.pop    (pop),
		.rdata  (rd_entry),
		.stat   (fifo_stat)
	);

	imta_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (rd_entry),
		.fifo_stat   (fifo_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tile_row    (tile_row),
		.tile_col    (tile_col),
		.tile_red    (tile_red),
		.tile_green  (tile_green),
		.tile_blue   (tile_blue),
		.image_done  (image_done),
		.image_red   (image_red),
		.image_green (image_green),
		.image_blue  (image_blue)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full) else $error("tile pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty) else $error("tile popped from an empty queue");

	a_image_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !image_done) |->
		(image_red == '0 && image_green == '0 && image_blue == '0))
		else $error("image average set on a tile that does not end the image");
`endif

endmodule
